// ===== hw/rtl/client_time_monitor_table_unit_macros.svh =====
// Assertion macros for the checker in ctmt_checker.sv.
`ifndef CLIENT_TIME_MONITOR_TABLE_UNIT_MACROS_SVH
`define CLIENT_TIME_MONITOR_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CTMT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CTMT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ctmt_pkg.sv =====
`default_nettype none
package ctmt_pkg;

   localparam int IP_W   = 32;
   localparam int SEC_W  = 32;
   localparam int FRAC_W = 32;
   localparam int NS_W   = 30;
   localparam int SLOT_W = 6;
   localparam int ACT_W  = 2;
   localparam int PROD_W = FRAC_W + NS_W;

   localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_WRITE
   } state_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_UPDATE  = 2'd0,
      ACT_FILL    = 2'd1,
      ACT_REPLACE = 2'd2
   } action_type;

endpackage
`default_nettype wire

// ===== hw/rtl/ctmt_ram.sv =====
`default_nettype none
module ctmt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ctmt_ns_conv.sv =====
`default_nettype none
module ctmt_ns_conv (
   input  wire logic                         clock,
   input  wire logic [ctmt_pkg::FRAC_W-1:0]  fraction,
   output logic      [ctmt_pkg::NS_W-1:0]    nanoseconds
);
   import ctmt_pkg::*;

   // The product of a 32-bit fraction and 1e9 shifted down by 32 is below 1e9.
   logic [PROD_W-1:0] product_ff;
   logic [PROD_W-1:0] product_in;

   assign product_in = PROD_W'(fraction) * PROD_W'(NS_PER_SEC);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign nanoseconds = product_ff[PROD_W-1:FRAC_W];

endmodule
`default_nettype wire

// ===== hw/rtl/client_time_monitor_table_unit.sv =====
`default_nettype none
// A request is taken in IDLE and runs through SCAN, DRAIN and WRITE; WRITE waits
// while a stalled result is still held. req_stall is high outside IDLE, so no new
// request is taken until the result is written. The scan reads the address memory one entry per cycle.
// Reset: synchronous, active high; it clears the per-entry valid bits (all
// entries read as empty), the replacement pointer and both handshakes.
module client_time_monitor_table_unit #(
   parameter int ENTRIES = 64
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [ctmt_pkg::IP_W-1:0]    req_client_ip,
   input  wire logic [ctmt_pkg::SEC_W-1:0]   req_offset_seconds,
   input  wire logic [ctmt_pkg::FRAC_W-1:0]  req_offset_fraction,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic      [ctmt_pkg::SLOT_W-1:0]  rsp_slot_index,
   output logic      [ctmt_pkg::ACT_W-1:0]   rsp_action_code,
   output logic      [ctmt_pkg::SEC_W-1:0]   rsp_stored_seconds,
   output logic      [ctmt_pkg::NS_W-1:0]    rsp_stored_nanoseconds
);
   import ctmt_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic                cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]    cmp_idx_ff, cmp_idx_in;
   logic                rd_vld_ff, rd_vld_in;
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic                empty_ff, empty_in;
   logic [IDX_W-1:0]    empty_idx_ff, empty_idx_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic [ENTRIES-1:0]  valid_ff, valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [IP_W-1:0]     ip_ff, ip_in;
   logic [SEC_W-1:0]    sec_ff, sec_in;
   logic [FRAC_W-1:0]   frac_ff, frac_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   action_type          rsp_act_ff, rsp_act_in;
   logic [SEC_W-1:0]    rsp_sec_ff, rsp_sec_in;
   logic [NS_W-1:0]     rsp_ns_ff, rsp_ns_in;

   logic                rd_en;
   logic [IDX_W-1:0]    rd_addr;
   logic [IP_W-1:0]     rd_data;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [IP_W-1:0]     entry_ip;
   logic [NS_W-1:0]     ns_value;
   logic [IDX_W-1:0]    slot;
   action_type          action;

   ctmt_ram #(
      .WIDTH (IP_W),
      .DEPTH (ENTRIES)
   ) u_addr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ip_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ctmt_ns_conv u_ns_conv (
      .clock       (clock),
      .fraction    (frac_ff),
      .nanoseconds (ns_value)
   );

   assign entry_ip = rd_vld_ff ? rd_data : '0;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cnt_ff;
      rd_vld_in    = rd_vld_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      empty_in     = empty_ff;
      empty_idx_in = empty_idx_ff;
      ptr_in       = ptr_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff;
      ip_in        = ip_ff;
      sec_in       = sec_ff;
      frac_in      = frac_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_sec_in   = rsp_sec_ff;
      rsp_ns_in    = rsp_ns_ff;
      rd_en        = 1'b0;
      rd_addr      = cnt_ff;
      wr_en        = 1'b0;
      slot         = ptr_ff;
      action       = ACT_REPLACE;
      req_stall    = 1'b1;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmp_valid_ff) begin
         if (!hit_ff && entry_ip == ip_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = cmp_idx_ff;
         end
         if (!empty_ff && entry_ip == '0) begin
            empty_in     = 1'b1;
            empty_idx_in = cmp_idx_ff;
         end
      end

      if (hit_ff) begin
         slot   = hit_idx_ff;
         action = ACT_UPDATE;
      end else if (empty_ff) begin
         slot   = empty_idx_ff;
         action = ACT_FILL;
      end
      wr_addr = slot;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ip_in    = req_client_ip;
               sec_in   = req_offset_seconds;
               frac_in  = req_offset_fraction;
               cnt_in   = '0;
               hit_in   = 1'b0;
               empty_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_en        = 1'b1;
            rd_vld_in    = valid_ff[cnt_ff];
            cmp_valid_in = 1'b1;
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               wr_en          = 1'b1;
               valid_in[slot] = 1'b1;
               if (action == ACT_REPLACE) begin
                  ptr_in = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
               end
               rsp_valid_in = 1'b1;
               rsp_slot_in  = SLOT_W'(slot);
               rsp_act_in   = action;
               rsp_sec_in   = sec_ff;
               rsp_ns_in    = ns_value;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cmp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         empty_ff     <= 1'b0;
         ptr_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cmp_valid_ff <= cmp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         hit_ff       <= hit_in;
         empty_ff     <= empty_in;
         ptr_ff       <= ptr_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_idx_ff   <= cmp_idx_in;
      hit_idx_ff   <= hit_idx_in;
      empty_idx_ff <= empty_idx_in;
      ip_ff        <= ip_in;
      sec_ff       <= sec_in;
      frac_ff      <= frac_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_act_ff   <= rsp_act_in;
      rsp_sec_ff   <= rsp_sec_in;
      rsp_ns_ff    <= rsp_ns_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_slot_index         = rsp_slot_ff;
   assign rsp_action_code        = rsp_act_ff;
   assign rsp_stored_seconds     = rsp_sec_ff;
   assign rsp_stored_nanoseconds = rsp_ns_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/ctmt_checker.sv =====
`default_nettype none
`include "client_time_monitor_table_unit_macros.svh"
module ctmt_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_stall,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   input  wire logic [ctmt_pkg::SLOT_W-1:0]  rsp_slot_index,
   input  wire logic [ctmt_pkg::ACT_W-1:0]   rsp_action_code,
   input  wire logic [ctmt_pkg::SEC_W-1:0]   rsp_stored_seconds,
   input  wire logic [ctmt_pkg::NS_W-1:0]    rsp_stored_nanoseconds
);
   import ctmt_pkg::*;

   `CTMT_ASSERT_NOW(a_action_legal, rsp_valid,
      rsp_action_code == ACT_UPDATE || rsp_action_code == ACT_FILL ||
      rsp_action_code == ACT_REPLACE, "Result carries an unknown action code.")
   `CTMT_ASSERT_NOW(a_ns_range, rsp_valid, rsp_stored_nanoseconds < NS_PER_SEC,
      "Stored nanoseconds reach one second.")
   `CTMT_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
      "A second request transaction was taken during a table scan.")
   `CTMT_ASSERT_NEXT(a_rsp_held, rsp_valid && rsp_stall, rsp_valid,
      "A stalled result transaction was dropped.")
   `CTMT_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall,
      $stable(rsp_slot_index) && $stable(rsp_action_code) &&
      $stable(rsp_stored_seconds) && $stable(rsp_stored_nanoseconds),
      "A stalled result transaction changed its payload.")

endmodule

bind client_time_monitor_table_unit ctmt_checker u_ctmt_checker (.*);
`default_nettype wire
